@@ hdl/dbq_pkg.sv @@
package dbq_pkg;

	localparam int SAMPLE_WIDTH   = 24;
	localparam int COEF_WIDTH     = 32;
	localparam int COEF_FRAC_BITS = 28;
	localparam int NUM_REGS       = 8;
	localparam int REG_IDX_W      = $clog2(NUM_REGS);

	// exact product, and the sum of five of them with headroom
	localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + 3;
	localparam int RND_W  = ACC_W - COEF_FRAC_BITS;

	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
	localparam logic signed [RND_W-1:0] SAMPLE_MAX =
		RND_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic signed [RND_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - RND_W'(1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOWPASS_B0  = 3'd0,
		REG_LOWPASS_B1  = 3'd1,
		REG_LOWPASS_B2  = 3'd2,
		REG_HIGHPASS_B0 = 3'd3,
		REG_HIGHPASS_B1 = 3'd4,
		REG_HIGHPASS_B2 = 3'd5,
		REG_FEEDBACK_A1 = 3'd6,
		REG_FEEDBACK_A2 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		coef_t b0;
		coef_t b1;
		coef_t b2;
	} ff_coef_t;

	typedef struct packed {
		coef_t a1;
		coef_t a2;
	} fb_coef_t;

	typedef struct packed {
		ff_coef_t lowpass;
		ff_coef_t highpass;
		fb_coef_t feedback;
	} coef_set_t;

	// pipeline control handed to each lane
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic clear;
	} lane_ctrl_t;

endpackage

@@ hdl/dbq_if.sv @@
interface dbq_in_if import dbq_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t lowpass_sample;
	sample_t highpass_sample;
	logic    clear_history;

	modport source (output valid, output lowpass_sample, output highpass_sample,
		output clear_history, input ready);
	modport sink (input valid, input lowpass_sample, input highpass_sample,
		input clear_history, output ready);
endinterface

interface dbq_out_if import dbq_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t lowpass_result;
	sample_t highpass_result;
	logic    saturated;

	modport source (output valid, output lowpass_result, output highpass_result,
		output saturated, input ready);
	modport sink (input valid, input lowpass_result, input highpass_result,
		input saturated, output ready);
endinterface

@@ hdl/dbq_coef_regs.sv @@
module dbq_coef_regs import dbq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COEF_WIDTH-1:0] cfg_data,
	output coef_set_t            coefs
);

	coef_set_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LOWPASS_B0:  coefs_q.lowpass.b0  <= coef_t'(cfg_data);
				REG_LOWPASS_B1:  coefs_q.lowpass.b1  <= coef_t'(cfg_data);
				REG_LOWPASS_B2:  coefs_q.lowpass.b2  <= coef_t'(cfg_data);
				REG_HIGHPASS_B0: coefs_q.highpass.b0 <= coef_t'(cfg_data);
				REG_HIGHPASS_B1: coefs_q.highpass.b1 <= coef_t'(cfg_data);
				REG_HIGHPASS_B2: coefs_q.highpass.b2 <= coef_t'(cfg_data);
				REG_FEEDBACK_A1: coefs_q.feedback.a1 <= coef_t'(cfg_data);
				REG_FEEDBACK_A2: coefs_q.feedback.a2 <= coef_t'(cfg_data);
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

@@ hdl/dbq_lane.sv @@
module dbq_lane import dbq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  ff_coef_t   ff,
	input  fb_coef_t   fb,
	input  sample_t    x,
	output sample_t    y,
	output logic       sat
);

	sample_t x1_q, x2_q, y1_q, y2_q;
	logic signed [ACC_W-1:0] ff_sum_s1;
	logic                    clear_s1;

	sample_t x1_eff, x2_eff, y1_eff, y2_eff;
	logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
	logic signed [ACC_W-1:0]  ff_sum, total;
	logic signed [RND_W-1:0]  rounded;

	// stage 1: feed-forward taps, independent of the recursion
	assign x1_eff = ctrl.clear ? '0 : x1_q;
	assign x2_eff = ctrl.clear ? '0 : x2_q;
	assign p0 = ff.b0 * x;
	assign p1 = ff.b1 * x1_eff;
	assign p2 = ff.b2 * x2_eff;
	assign ff_sum = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (ctrl.load_s1) begin
			x1_q <= x;
			x2_q <= x1_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			ff_sum_s1 <= ff_sum;
			clear_s1  <= ctrl.clear;
		end
	end

	// stage 2: feedback, round half up, clip
	assign y1_eff = clear_s1 ? '0 : y1_q;
	assign y2_eff = clear_s1 ? '0 : y2_q;
	assign p3 = fb.a1 * y1_eff;
	assign p4 = fb.a2 * y2_eff;
	assign total = ff_sum_s1 - ACC_W'(p3) - ACC_W'(p4) + ROUND_HALF;
	assign rounded = total[ACC_W-1:COEF_FRAC_BITS];

	always_comb begin
		sat = 1'b0;
		y   = rounded[SAMPLE_WIDTH-1:0];
		if (rounded > SAMPLE_MAX) begin
			sat = 1'b1;
			y   = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
		end else if (rounded < SAMPLE_MIN) begin
			sat = 1'b1;
			y   = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctrl.load_s2) begin
			y1_q <= y;
			y2_q <= y1_eff;
		end
	end

endmodule

@@ hdl/dual_biquad_iir_filter_core.sv @@
// Dual direct-form-I biquad: a low-pass and a high-pass lane filtered side by side.
// samples: valid/ready channel, one request carries one sample per lane and a
// clear_history flag that zeroes both lanes' history before that request is filtered.
// results: valid/ready channel, one request per input request, in order, with both
// lane outputs (rounded half up, clipped to sample width) and a saturated flag.
// Coefficients are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// A request accepted into the stage 1 registers moves on to the output register and
// is presented on results from there. Throughput: one request per cycle while results
// is not stalled. Stage 1 forms the three feed-forward products; stage 2 closes the
// recursion (two feedback products, sum, round, clip) combinationally, and that path
// sets the clock period. If results stalls, the output register holds its request and
// stage 1 can still take one more; samples.ready drops once both are full.
// Reset (arst_n low) clears coefficients, all history and the valid flags.
module dual_biquad_iir_filter_core import dbq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dbq_in_if.sink                samples,
	dbq_out_if.source             results,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0] cfg_data
);

	coef_set_t  coefs;
	lane_ctrl_t ctrl;
	logic       s1_valid_q, out_valid_q;
	sample_t    y_low, y_high;
	logic       sat_low, sat_high;
	sample_t    low_q, high_q;
	logic       sat_q;

	dbq_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	assign ctrl.load_s2 = s1_valid_q && (!out_valid_q || results.ready);
	assign samples.ready = !s1_valid_q || ctrl.load_s2;
	assign ctrl.load_s1 = samples.valid && samples.ready;
	assign ctrl.clear   = samples.clear_history;

	dbq_lane u_lane_low (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ff     (coefs.lowpass),
		.fb     (coefs.feedback),
		.x      (samples.lowpass_sample),
		.y      (y_low),
		.sat    (sat_low)
	);

	dbq_lane u_lane_high (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ff     (coefs.highpass),
		.fb     (coefs.feedback),
		.x      (samples.highpass_sample),
		.y      (y_high),
		.sat    (sat_high)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_s1)
				s1_valid_q <= 1'b1;
			else if (ctrl.load_s2)
				s1_valid_q <= 1'b0;
			if (ctrl.load_s2)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	// merge: both lane outputs and the combined clip flag
	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			low_q  <= y_low;
			high_q <= y_high;
			sat_q  <= sat_low | sat_high;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.lowpass_result  = low_q;
	assign results.highpass_result = high_q;
	assign results.saturated       = sat_q;

endmodule

@@ test/tb.sv @@
module tb;
	import dbq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		sample_t lp;
		sample_t hp;
		logic    clr;
	} sample_rec_t;

	typedef struct packed {
		sample_t lp;
		sample_t hp;
		logic    sat;
	} filt_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [COEF_WIDTH-1:0] cfg_data = '0;

	logic        drv_valid = 1'b0;
	sample_rec_t drv_item = '0;
	logic        res_ready = 1'b0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic pressure_on = 1'b0;
	logic pressure_q = 1'b0;
	int hold_left = 0;

	int mismatches = 0;
	int cycles = 0;

	sample_rec_t sample_q[$];
	filt_rec_t   filtered_q[$];

	// filter state as seen from outside
	coef_t   coef_m[NUM_REGS] = '{default: '0};
	sample_t x_hist[4] = '{default: '0};
	sample_t y_hist[4] = '{default: '0};

	dbq_in_if  samples_if ();
	dbq_out_if results_if ();

	assign samples_if.valid           = drv_valid;
	assign samples_if.lowpass_sample  = drv_item.lp;
	assign samples_if.highpass_sample = drv_item.hp;
	assign samples_if.clear_history   = drv_item.clr;
	assign results_if.ready           = res_ready;

	dual_biquad_iir_filter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("MISMATCH @%0d: %s", cycles, msg);
		mismatches++;
	endtask

	// one direct form I section; base picks the lane's history slots
	function automatic void run_lane(input sample_t x, input coef_t b0, input coef_t b1,
			input coef_t b2, input int base, output sample_t y, output logic sat);
		longint acc;
		longint rnd;
		longint lim_hi;
		longint lim_lo;
		acc = longint'(b0) * longint'(x)
			+ longint'(b1) * longint'(x_hist[base])
			+ longint'(b2) * longint'(x_hist[base+1])
			- longint'(coef_m[REG_FEEDBACK_A1]) * longint'(y_hist[base])
			- longint'(coef_m[REG_FEEDBACK_A2]) * longint'(y_hist[base+1]);
		rnd = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
		lim_hi = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
		lim_lo = -lim_hi - 64'sd1;
		sat = 1'b0;
		if (rnd > lim_hi) begin
			rnd = lim_hi;
			sat = 1'b1;
		end
		if (rnd < lim_lo) begin
			rnd = lim_lo;
			sat = 1'b1;
		end
		y = sample_t'(rnd);
		x_hist[base+1] = x_hist[base];
		x_hist[base]   = x;
		y_hist[base+1] = y_hist[base];
		y_hist[base]   = y;
	endfunction

	function automatic void filter_sample(input sample_rec_t s);
		filt_rec_t r;
		logic sl;
		logic sh;
		if (s.clr) begin
			x_hist = '{default: '0};
			y_hist = '{default: '0};
		end
		run_lane(s.lp, coef_m[REG_LOWPASS_B0], coef_m[REG_LOWPASS_B1],
			coef_m[REG_LOWPASS_B2], 0, r.lp, sl);
		run_lane(s.hp, coef_m[REG_HIGHPASS_B0], coef_m[REG_HIGHPASS_B1],
			coef_m[REG_HIGHPASS_B2], 2, r.hp, sh);
		r.sat = sl | sh;
		filtered_q.push_back(r);
	endfunction

	function automatic sample_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return sample_t'($urandom);
		else if (r < 9)
			return sample_t'(int'($urandom_range(0, 8191)) - 4096);
		case ($urandom_range(0, 3))
			0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic coef_t extreme_coef();
		case ($urandom_range(0, 3))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			default: return 32'sh1000_0000;
		endcase
	endfunction

	function automatic void pick_coefs(input int kind, output coef_t c[NUM_REGS]);
		int k;
		int h;
		for (int i = 0; i < NUM_REGS; i++) begin
			case (kind)
				1: c[i] = coef_t'($urandom);
				2: c[i] = coef_t'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
				default: c[i] = extreme_coef();
			endcase
		end
		if (kind == 0) begin
			// plausible low-pass / high-pass pair sharing the poles
			k = $urandom_range(1 << 18, 1 << 24);
			h = $urandom_range(200000000, 260000000);
			c[REG_LOWPASS_B0]  = coef_t'(k);
			c[REG_LOWPASS_B1]  = coef_t'(2 * k);
			c[REG_LOWPASS_B2]  = coef_t'(k);
			c[REG_HIGHPASS_B0] = coef_t'(h);
			c[REG_HIGHPASS_B1] = coef_t'(-2 * h);
			c[REG_HIGHPASS_B2] = coef_t'(h);
			c[REG_FEEDBACK_A1] = coef_t'(-int'($urandom_range(402653184, 456340275)));
			c[REG_FEEDBACK_A2] = coef_t'($urandom_range(187904819, 241591910));
		end
	endfunction

	task automatic load_coefs(input coef_t c[NUM_REGS]);
		@(posedge clk);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= c[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic add_item(input sample_t lp, input sample_t hp, input logic clr);
		sample_rec_t s;
		s.lp  = lp;
		s.hp  = hp;
		s.clr = clr;
		sample_q.push_back(s);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || drv_valid || filtered_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_we)
			coef_m[cfg_index] <= coef_t'(cfg_data);
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && samples_if.ready)
				filter_sample(drv_item);
			if (!drv_valid || samples_if.ready) begin
				if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_item  <= sample_q.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// result side back-pressure; long hold when pressure starts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			hold_left  <= 0;
			pressure_q <= 1'b0;
		end else begin
			pressure_q <= pressure_on;
			if (pressure_on && !pressure_q) begin
				hold_left <= 48;
				res_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_ready <= 1'b0;
			end else if (pressure_on && $urandom_range(0, 39) == 0) begin
				hold_left <= $urandom_range(20, 60);
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		filt_rec_t e;
		if (arst_n && results_if.valid && res_ready) begin
			if (filtered_q.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				e = filtered_q.pop_front();
				if (results_if.lowpass_result !== e.lp)
					report_mismatch($sformatf("lowpass_result %0d, expected %0d",
						results_if.lowpass_result, e.lp));
				if (results_if.highpass_result !== e.hp)
					report_mismatch($sformatf("highpass_result %0d, expected %0d",
						results_if.highpass_result, e.hp));
				if (results_if.saturated !== e.sat)
					report_mismatch($sformatf("saturated %b, expected %b",
						results_if.saturated, e.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** dual_biquad_iir_filter_core: FAILED **");
			$finish;
		end
	end

	initial begin
		coef_t c[NUM_REGS];
		sample_t smax;
		sample_t smin;
		smax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		smin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// unity low-pass, half-gain high-pass: pass-through and round half up
		c = '{default: '0};
		c[REG_LOWPASS_B0]  = 32'sh1000_0000;
		c[REG_HIGHPASS_B0] = 32'sh0800_0000;
		load_coefs(c);
		@(negedge clk);
		add_item(smax, 24'sd1, 1'b0);
		add_item(smin, -24'sd1, 1'b0);
		add_item('0, 24'sd3, 1'b0);
		add_item(-24'sd1, -24'sd3, 1'b0);
		add_item(24'sh555555, 24'shAAAAAA, 1'b0);
		add_item(24'shAAAAAA, 24'sh555555, 1'b0);
		add_item(smax, smax, 1'b0);
		add_item(smin, smin, 1'b0);
		wait_idle();

		// coefficient extremes: clipping both ways
		c[REG_LOWPASS_B0]  = 32'sh7FFF_FFFF;
		c[REG_LOWPASS_B1]  = 32'sh8000_0000;
		c[REG_LOWPASS_B2]  = 32'sh7FFF_FFFF;
		c[REG_HIGHPASS_B0] = 32'sh8000_0000;
		c[REG_HIGHPASS_B1] = 32'sh7FFF_FFFF;
		c[REG_HIGHPASS_B2] = 32'sh8000_0000;
		c[REG_FEEDBACK_A1] = 32'sh8000_0000;
		c[REG_FEEDBACK_A2] = 32'sh7FFF_FFFF;
		load_coefs(c);
		@(negedge clk);
		add_item(smax, smax, 1'b1);
		add_item(smin, smin, 1'b0);
		add_item(smax, smin, 1'b0);
		add_item('0, '0, 1'b0);
		add_item(24'sd1, -24'sd1, 1'b1);
		add_item(smin, smax, 1'b0);
		add_item('0, '0, 1'b1);
		wait_idle();

		// resonant section; clear_history mid-stream
		pick_coefs(0, c);
		load_coefs(c);
		@(negedge clk);
		add_item(24'sd100000, 24'sd100000, 1'b0);
		add_item(24'sd100000, 24'sd100000, 1'b0);
		add_item(24'sd100000, -24'sd100000, 1'b0);
		add_item('0, '0, 1'b1);
		add_item(24'sd100000, -24'sd100000, 1'b0);
		add_item('0, '0, 1'b0);
		wait_idle();

		for (int p = 0; p < 9; p++) begin
			pick_coefs(p % 4, c);
			load_coefs(c);
			@(negedge clk);
			case (p % 5)
				0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
				1: begin send_idle_pct <= 66; stall_pct <= 0;  end
				2: begin send_idle_pct <= 0;  stall_pct <= 66; end
				3: begin send_idle_pct <= 28; stall_pct <= 28; end
				default: begin send_idle_pct <= 0; stall_pct <= 10; end
			endcase
			for (int n = 0; n < 100; n++)
				add_item(rand_sample(), rand_sample(), $urandom_range(0, 24) == 0);
			if (p % 5 == 4)
				pressure_on <= 1'b1;
			wait_idle();
			pressure_on <= 1'b0;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (filtered_q.size() != 0)
			report_mismatch("results still outstanding at end of run");
		if (mismatches == 0)
			$display("** dual_biquad_iir_filter_core: PASSED **");
		else
			$display("** dual_biquad_iir_filter_core: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/dbq_pkg.sv
hdl/dbq_if.sv
hdl/dbq_coef_regs.sv
hdl/dbq_lane.sv
hdl/dual_biquad_iir_filter_core.sv
test/tb.sv
